### hw/rtl/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder package
// Shared state encoding for the code builder sequencer.
// ----------------------------------------------------------------------------
package hcb_pkg;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_SCAN_A,
        ST_SCAN_B,
        ST_MERGE,
        ST_MERGE_B,
        ST_WALK_START,
        ST_WALK_RD,
        ST_WALK_STEP,
        ST_EMIT
    } hcb_state_t;

endpackage

### hw/rtl/huffman_code_builder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Huffman code builder
// Loads weighted leaves, builds a Huffman tree in node memory, emits codes.
// ----------------------------------------------------------------------------
// Leaves are loaded one per transaction. A set of n leaves then has its
// weights moved and its tree built: two scans of slots i+1..2n-1 at one entry
// per cycle and three writes per merge. Each code is then walked from its leaf
// to the root, and emission waits on any output stall. The build of a set is
// bounded by the single read port of node memory.
// Reset (aresetn low, synchronous) empties the leaf set; memory is not cleared.
// ----------------------------------------------------------------------------
module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_LEAVES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [7:0] symbol, [23:8] weight
    input  logic        s_tlast,   // last_leaf
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_symbol, [23:8] code_bits, [28:24] code_length
    output logic        m_tlast    // last_code
);

    localparam int SLOTS = 2 * MAX_LEAVES;
    localparam int SW    = $clog2(SLOTS);
    localparam int LW    = $clog2(MAX_LEAVES);
    localparam int CW    = $clog2(MAX_LEAVES + 1);

    // Node memory entry: weight, parent, left child, has-parent flag.
    typedef struct packed {
        logic [19:0]   weight;
        logic [SW-1:0] parent;
        logic [SW-1:0] left;
        logic          linked;
    } node_t;

    node_t      node_mem [SLOTS];
    logic [7:0] sym_mem  [MAX_LEAVES];

    hcb_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;   // leaves in set
    logic [SW-1:0] addr_reg, addr_next;     // scan / walk pointer
    logic [SW-1:0] node_i_reg, node_i_next; // internal node under construction
    logic [SW-1:0] best_reg, best_next;
    logic [19:0]   best_w_reg, best_w_next;
    logic [SW-1:0] best_l_reg, best_l_next;
    logic          found_reg, found_next;
    logic [SW-1:0] a_reg, a_next;
    logic [19:0]   a_w_reg, a_w_next;
    logic [SW-1:0] a_l_reg, a_l_next;
    logic [LW-1:0] j_reg, j_next;           // leaf index for move and emit
    logic [SW-1:0] child_reg, child_next;
    logic [15:0]   code_reg, code_next;
    logic [4:0]    len_reg, len_next;

    logic          rd_en;
    logic [SW-1:0] rd_addr;
    node_t         rd_q;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    node_t         wr_data;
    logic [7:0]    sym_q;

    logic          m_valid_reg, m_valid_next;
    logic [31:0]   m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    logic [SW-1:0] top;
    logic          in_acc;
    logic          scan_end;
    logic          closes;

    assign top      = SW'(2 * count_reg - 1);
    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign scan_end = (addr_reg == top);
    assign closes   = s_tlast || (count_reg == CW'(MAX_LEAVES - 1));

    // A read of the entry written in the same cycle returns the new data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_q <= wr_data;
            end else begin
                rd_q <= node_mem[rd_addr];
            end
        end
        if (wr_en) begin
            node_mem[wr_addr] <= wr_data;
        end
        if (in_acc) begin
            sym_mem[count_reg[LW-1:0]] <= s_tdata[7:0];
        end
        sym_q <= sym_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        addr_reg   <= addr_next;
        node_i_reg <= node_i_next;
        best_reg   <= best_next;
        best_w_reg <= best_w_next;
        best_l_reg <= best_l_next;
        found_reg  <= found_next;
        a_reg      <= a_next;
        a_w_reg    <= a_w_next;
        a_l_reg    <= a_l_next;
        j_reg      <= j_next;
        child_reg  <= child_next;
        code_reg   <= code_next;
        len_reg    <= len_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        addr_next    = addr_reg;
        node_i_next  = node_i_reg;
        best_next    = best_reg;
        best_w_next  = best_w_reg;
        best_l_next  = best_l_reg;
        found_next   = found_reg;
        a_next       = a_reg;
        a_w_next     = a_w_reg;
        a_l_next     = a_l_reg;
        j_next       = j_reg;
        child_next   = child_reg;
        code_next    = code_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        rd_en        = 1'b0;
        rd_addr      = addr_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_LOAD: begin
                if (in_acc) begin
                    // Weight parked by leaf index in slots 0..n-1.
                    wr_en          = 1'b1;
                    wr_addr        = SW'(count_reg);
                    wr_data.weight = {4'd0, s_tdata[23:8]};
                    count_next     = count_reg + 1'b1;
                    if (closes) begin
                        // Move from the highest leaf down so no source is
                        // overwritten before it is read.
                        j_next     = LW'(count_reg);
                        state_next = ST_MOVE_RD;
                    end
                end
            end
            ST_MOVE_RD: begin
                rd_en      = 1'b1;
                rd_addr    = SW'(j_reg);
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                wr_en          = 1'b1;
                wr_addr        = top - SW'(j_reg);
                wr_data.weight = rd_q.weight;
                if (j_reg == '0) begin
                    node_i_next = SW'(count_reg - 1'b1);
                    if (count_reg == CW'(1)) begin
                        j_next     = '0;
                        state_next = ST_WALK_START;
                    end else begin
                        addr_next  = SW'(count_reg);
                        found_next = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = SW'(count_reg);
                        state_next = ST_SCAN_A;
                    end
                end else begin
                    j_next     = j_reg - 1'b1;
                    state_next = ST_MOVE_RD;
                end
            end
            ST_SCAN_A, ST_SCAN_B: begin
                // rd_q holds entry addr_reg; issue the next read each cycle.
                if (!rd_q.linked && !(state_reg == ST_SCAN_B && addr_reg == a_reg)
                        && (!found_reg || rd_q.weight < best_w_reg)) begin
                    best_next   = addr_reg;
                    best_w_next = rd_q.weight;
                    best_l_next = rd_q.left;
                    found_next  = 1'b1;
                end
                if (scan_end) begin
                    addr_next  = node_i_reg + 1'b1;
                    found_next = 1'b0;
                    if (state_reg == ST_SCAN_A) begin
                        a_next   = best_next;
                        a_w_next = best_w_next;
                        a_l_next = best_l_next;
                        rd_en    = 1'b1;
                        rd_addr  = node_i_reg + 1'b1;
                        state_next = ST_SCAN_B;
                    end else begin
                        state_next = ST_MERGE;
                    end
                end else begin
                    addr_next = addr_reg + 1'b1;
                    rd_en     = 1'b1;
                    rd_addr   = addr_reg + 1'b1;
                end
            end
            ST_MERGE: begin
                // Link the first child. Its weight and left child were
                // captured by the scan, so the whole entry is rewritten.
                wr_en          = 1'b1;
                wr_addr        = a_reg;
                wr_data.weight = a_w_reg;
                wr_data.parent = node_i_reg;
                wr_data.left   = a_l_reg;
                wr_data.linked = 1'b1;
                state_next     = ST_MERGE_B;
            end
            ST_MERGE_B: begin
                // Link the second child.
                wr_en          = 1'b1;
                wr_addr        = best_reg;
                wr_data.weight = best_w_reg;
                wr_data.parent = node_i_reg;
                wr_data.left   = best_l_reg;
                wr_data.linked = 1'b1;
                state_next     = ST_WALK_START;
            end
            ST_WALK_START: begin
                if (node_i_reg != '0 && count_reg != CW'(1)) begin
                    // Finish the merge: store the new internal node.
                    wr_en          = 1'b1;
                    wr_addr        = node_i_reg;
                    wr_data.weight = a_w_reg + best_w_reg;
                    wr_data.left   = a_reg;
                    wr_data.linked = 1'b0;
                    node_i_next    = node_i_reg - 1'b1;
                    if (node_i_reg == SW'(1)) begin
                        j_next = '0;
                    end else begin
                        addr_next  = node_i_reg;
                        found_next = 1'b0;
                        rd_en      = 1'b1;
                        rd_addr    = node_i_reg;
                        state_next = ST_SCAN_A;
                    end
                end else if (!m_valid_reg || m_tready) begin
                    child_next = top - SW'(j_reg);
                    code_next  = '0;
                    len_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = top - SW'(j_reg);
                    state_next = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                // rd_q is child entry.
                if (count_reg != CW'(1) && rd_q.linked) begin
                    rd_en      = 1'b1;
                    rd_addr    = rd_q.parent;
                    addr_next  = rd_q.parent;
                    state_next = ST_WALK_STEP;
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_WALK_STEP: begin
                // rd_q is the parent entry. Only the sixteen bits nearest the
                // leaf are kept in the code.
                if (len_reg < 5'd16) begin
                    code_next[len_reg[3:0]] = (rd_q.left != child_reg);
                end
                if (len_reg != 5'd31) begin
                    len_next = len_reg + 1'b1;
                end
                child_next = addr_reg;
                rd_en      = 1'b1;
                rd_addr    = addr_reg;
                state_next = ST_WALK_RD;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {3'd0, (len_reg == '0) ? 5'd1 : len_reg, code_reg, sym_q};
                    m_last_next  = (CW'(j_reg) == count_reg - 1'b1);
                    if (CW'(j_reg) == count_reg - 1'b1) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_WALK_START;
                        node_i_next = '0;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    property p_no_accept_busy;
        @(posedge aclk) disable iff (!aresetn) (state_reg != ST_LOAD) |-> !s_tready;
    endproperty
    a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

    property p_count_bound;
        @(posedge aclk) disable iff (!aresetn) count_reg <= CW'(MAX_LEAVES);
    endproperty
    a_count_bound: assert property (p_count_bound) else $error("leaf count overflow");

    property p_emit_hold;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid_reg && !m_tready) |=> $stable(m_data_reg);
    endproperty
    a_emit_hold: assert property (p_emit_hold) else $error("result changed while stalled");

endmodule
